/* src/lfpd_pkg.sv */
// Shared types and constants of the line follower PD drive block.
package lfpd_pkg;

    // Field widths
    localparam int CMD_W     = 2;
    localparam int POS_W     = 13;
    localparam int SENSE_W   = 10;
    localparam int SPEED_W   = 10;
    localparam int GAIN_W    = 12;
    localparam int LIMIT_W   = 9;
    localparam int ERR_W     = 13;

    // Sensor fields carried on the input stream
    localparam int SENSOR_FIELDS  = 6;
    localparam int SENSOR_COUNT_D = 6;

    // Stream payload layout
    localparam int S_TDATA_W = 96;
    localparam int S_TUSER_W = CMD_W;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 2;

    localparam int POS_LSB    = 0;
    localparam int SENSOR_LSB = POS_LSB + POS_W;
    localparam int LSPD_LSB   = SENSOR_LSB + SENSOR_FIELDS * SENSE_W;
    localparam int RSPD_LSB   = LSPD_LSB + SPEED_W;

    // APB register map
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    localparam logic [2:0] REG_KP     = 3'd0;
    localparam logic [2:0] REG_KD     = 3'd1;
    localparam logic [2:0] REG_THRESH = 3'd2;
    localparam logic [2:0] REG_CENTER = 3'd3;
    localparam logic [2:0] REG_LIMIT  = 3'd4;
    localparam logic [2:0] REG_DEADB  = 3'd5;

    // Register reset values
    localparam logic [GAIN_W-1:0]  KP_RST     = 12'd38;
    localparam logic [GAIN_W-1:0]  KD_RST     = 12'd13;
    localparam logic [SENSE_W-1:0] THRESH_RST = 10'd800;
    localparam logic [POS_W-1:0]   CENTER_RST = 13'd2500;
    localparam logic [LIMIT_W-1:0] LIMIT_RST  = 9'd200;
    localparam logic [SENSE_W-1:0] DEADB_RST  = 10'd200;

    // Item kinds
    typedef enum logic [CMD_W-1:0] {
        CMD_SAMPLE  = 2'd0,
        CMD_SET     = 2'd1,
        CMD_RESTORE = 2'd2,
        CMD_NOP     = 2'd3
    } t_cmd;

    // Configuration handed from the register file to the datapath
    typedef struct packed {
        logic [GAIN_W-1:0]  kp_gain;
        logic [GAIN_W-1:0]  kd_gain;
        logic [SENSE_W-1:0] sense_level;
        logic [POS_W-1:0]   center_position;
        logic [LIMIT_W-1:0] speed_limit;
        logic [SENSE_W-1:0] error_deadband;
    } t_cfg;

endpackage

/* src/line_follow_pd_drive_top.sv */
// Top level of the line follower PD drive block: stream pipeline and drive state.
//
// Usage:
//   Items arrive on the s_axis stream: tuser carries the command (sample, set
//   base speeds, restore previous bases), tdata the line position, six sensor
//   reflectances and the two new base speeds. Each item yields exactly one
//   result on the m_axis stream: left/right drive in tdata, drive_valid and
//   crossing_event in tuser. Gains, threshold, center, limit and deadband are
//   set through the APB port while no item is in flight.
//   Pipeline: each item passes three registers in order (input register,
//   product register, output register) before it is offered on m_axis.
//   Throughput: one item per cycle while the receiver does not stall; the
//   PD state (previous error, bases, crossing flag) is updated in the
//   product stage, so each item sees the state its predecessor left.
//   Reset (synchronous, active low) empties the pipeline, zeroes the drive
//   state and loads the register reset values.
//   When the receiver stalls, the three stages keep filling; s_axis_tready
//   falls only once all of them hold an item.
module line_follow_pd_drive_top #(
    parameter int SENSOR_COUNT = lfpd_pkg::SENSOR_COUNT_D
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [12:0] line_pos, [22:13] sensor_0 .. [72:63] sensor_5,
    // [82:73] left_speed, [92:83] right_speed, [95:93] zero
    input  logic [lfpd_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] cmd
    input  logic [lfpd_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [9:0] left_drive, [19:10] right_drive, [23:20] zero
    output logic [lfpd_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // [0] drive_valid, [1] crossing_event
    output logic [lfpd_pkg::M_TUSER_W-1:0]  m_axis_tuser,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lfpd_pkg::APB_AW-1:0]     paddr,
    input  logic [lfpd_pkg::APB_DW-1:0]     pwdata,
    output logic [lfpd_pkg::APB_DW-1:0]     prdata,
    output logic                            pready
);
    import lfpd_pkg::*;

    localparam int DIFF_W = ERR_W + 1;
    localparam int KP_W   = GAIN_W + 1 + ERR_W;
    localparam int KD_W   = GAIN_W + 1 + DIFF_W;
    localparam int SUM_W  = KD_W + 1;
    localparam int CORR_W = SUM_W - 8;
    localparam int DRV_W  = CORR_W + 1;

    t_cfg w_cfg;

    lfpd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // ---------------- stage handshake ----------------
    logic w_rdy1, w_rdy2, w_rdy3;
    logic r_s1_valid, r_s2_valid, r_o_valid;

    assign w_rdy3        = !r_o_valid || m_axis_tready;
    assign w_rdy2        = !r_s2_valid || w_rdy3;
    assign w_rdy1        = !r_s1_valid || w_rdy2;
    assign s_axis_tready = w_rdy1;

    // ---------------- input stage: error and crossing test ----------------
    logic signed [POS_W:0]   w_raw_err;
    logic signed [ERR_W-1:0] w_err;
    logic                    w_all;

    always_comb begin
        w_raw_err = $signed({1'b0, s_axis_tdata[POS_LSB +: POS_W]})
                  - $signed({1'b0, w_cfg.center_position});
        if (w_raw_err < -(14'sd4096))
            w_err = -(13'sd4096);
        else if (w_raw_err > 14'sd4095)
            w_err = 13'sd4095;
        else
            w_err = w_raw_err[ERR_W-1:0];
        // every enabled sensor must read above the threshold
        w_all = 1'b1;
        for (int i = 0; i < SENSOR_FIELDS; i++) begin
            if (i < SENSOR_COUNT &&
                s_axis_tdata[SENSOR_LSB + SENSE_W*i +: SENSE_W] <= w_cfg.sense_level)
                w_all = 1'b0;
        end
    end

    t_cmd                      r_s1_cmd;
    logic signed [ERR_W-1:0]   r_s1_err;
    logic                      r_s1_all;
    logic signed [SPEED_W-1:0] r_s1_lspd, r_s1_rspd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_s1_valid <= 1'b0;
        else if (w_rdy1)
            r_s1_valid <= s_axis_tvalid;
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_s1_cmd  <= t_cmd'(s_axis_tuser);
            r_s1_err  <= w_err;
            r_s1_all  <= w_all;
            r_s1_lspd <= s_axis_tdata[LSPD_LSB +: SPEED_W];
            r_s1_rspd <= s_axis_tdata[RSPD_LSB +: SPEED_W];
        end
    end

    // ---------------- product stage: state update and gains ----------------
    logic signed [ERR_W-1:0]   r_prev_err;
    logic                      r_on_cross;
    logic signed [SPEED_W-1:0] r_lbase, r_rbase, r_plbase, r_prbase;

    logic signed [ERR_W-1:0]   n_prev_err;
    logic                      n_on_cross;
    logic signed [SPEED_W-1:0] n_lbase, n_rbase, n_plbase, n_prbase;
    logic                      w_event;
    logic signed [DIFF_W-1:0]  w_diff;
    logic [DIFF_W-1:0]         w_abs_err;
    logic signed [KP_W-1:0]    w_kp_prod;
    logic signed [KD_W-1:0]    w_kd_prod;
    logic                      w_quiet;
    logic                      w_s2_load;

    assign w_s2_load = r_s1_valid && w_rdy2;

    always_comb begin
        n_prev_err = r_prev_err;
        n_on_cross = r_on_cross;
        n_lbase    = r_lbase;
        n_rbase    = r_rbase;
        n_plbase   = r_plbase;
        n_prbase   = r_prbase;
        w_event    = 1'b0;
        case (r_s1_cmd)
            CMD_SAMPLE: begin
                // first sample on a crossing stops the drive
                if (r_s1_all && !r_on_cross) begin
                    n_plbase = r_lbase;
                    n_prbase = r_rbase;
                    n_lbase  = '0;
                    n_rbase  = '0;
                    w_event  = 1'b1;
                end
                n_on_cross = r_s1_all;
                n_prev_err = r_s1_err;
            end
            CMD_SET: begin
                n_plbase = r_lbase;
                n_prbase = r_rbase;
                n_lbase  = r_s1_lspd;
                n_rbase  = r_s1_rspd;
            end
            CMD_RESTORE: begin
                n_lbase = r_plbase;
                n_rbase = r_prbase;
            end
            default: ;
        endcase

        w_diff    = DIFF_W'(r_s1_err) - DIFF_W'(r_prev_err);
        w_abs_err = r_s1_err[ERR_W-1] ? DIFF_W'(-DIFF_W'(r_s1_err)) : DIFF_W'(r_s1_err);
        w_kp_prod = $signed({1'b0, w_cfg.kp_gain}) * r_s1_err;
        w_kd_prod = $signed({1'b0, w_cfg.kd_gain}) * w_diff;
        // stopped robot inside the deadband stays silent
        w_quiet   = (w_abs_err < DIFF_W'(w_cfg.error_deadband)) &&
                    (n_lbase == '0) && (n_rbase == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_prev_err <= '0;
            r_on_cross <= 1'b0;
            r_lbase    <= '0;
            r_rbase    <= '0;
            r_plbase   <= '0;
            r_prbase   <= '0;
        end else begin
            if (w_rdy2)
                r_s2_valid <= r_s1_valid;
            if (w_s2_load) begin
                r_prev_err <= n_prev_err;
                r_on_cross <= n_on_cross;
                r_lbase    <= n_lbase;
                r_rbase    <= n_rbase;
                r_plbase   <= n_plbase;
                r_prbase   <= n_prbase;
            end
        end
    end

    t_cmd                      r_s2_cmd;
    logic signed [KP_W-1:0]    r_s2_kp;
    logic signed [KD_W-1:0]    r_s2_kd;
    logic signed [SPEED_W-1:0] r_s2_lb, r_s2_rb;
    logic                      r_s2_quiet, r_s2_event;

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r_s2_cmd   <= r_s1_cmd;
            r_s2_kp    <= w_kp_prod;
            r_s2_kd    <= w_kd_prod;
            r_s2_lb    <= n_lbase;
            r_s2_rb    <= n_rbase;
            r_s2_quiet <= w_quiet;
            r_s2_event <= w_event;
        end
    end

    // ---------------- output stage: correction and clamp ----------------
    logic signed [SUM_W-1:0]   w_sum, w_adj;
    logic signed [CORR_W-1:0]  w_corr;
    logic signed [DRV_W-1:0]   w_lsum, w_rsum, w_lim;
    logic signed [SPEED_W-1:0] n_o_ld, n_o_rd, w_lclamp, w_rclamp;
    logic                      n_o_dv, n_o_ev;

    always_comb begin
        w_sum  = SUM_W'(r_s2_kp) + SUM_W'(r_s2_kd);
        // divide by 256, rounding toward zero
        w_adj  = w_sum + (w_sum[SUM_W-1] ? SUM_W'(255) : SUM_W'(0));
        w_corr = w_adj[SUM_W-1:8];
        w_lsum = DRV_W'(r_s2_lb) + DRV_W'(w_corr);
        w_rsum = DRV_W'(r_s2_rb) - DRV_W'(w_corr);
        w_lim  = $signed({{(DRV_W-LIMIT_W){1'b0}}, w_cfg.speed_limit});

        if (w_lsum > w_lim)
            w_lclamp = w_lim[SPEED_W-1:0];
        else if (w_lsum < -w_lim)
            w_lclamp = SPEED_W'(-w_lim);
        else
            w_lclamp = w_lsum[SPEED_W-1:0];

        if (w_rsum > w_lim)
            w_rclamp = w_lim[SPEED_W-1:0];
        else if (w_rsum < -w_lim)
            w_rclamp = SPEED_W'(-w_lim);
        else
            w_rclamp = w_rsum[SPEED_W-1:0];

        n_o_ld = '0;
        n_o_rd = '0;
        n_o_dv = 1'b0;
        n_o_ev = 1'b0;
        case (r_s2_cmd)
            CMD_SAMPLE: begin
                n_o_ev = r_s2_event;
                n_o_dv = r_s2_event || !r_s2_quiet;
                if (!r_s2_quiet) begin
                    n_o_ld = w_lclamp;
                    n_o_rd = w_rclamp;
                end
            end
            CMD_SET, CMD_RESTORE: begin
                n_o_ld = r_s2_lb;
                n_o_rd = r_s2_rb;
                n_o_dv = 1'b1;
            end
            default: ;
        endcase
    end

    logic signed [SPEED_W-1:0] r_o_ld, r_o_rd;
    logic                      r_o_dv, r_o_ev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_o_valid <= 1'b0;
        else if (w_rdy3)
            r_o_valid <= r_s2_valid;
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r_o_ld <= n_o_ld;
            r_o_rd <= n_o_rd;
            r_o_dv <= n_o_dv;
            r_o_ev <= n_o_ev;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {{(M_TDATA_W - 2*SPEED_W){1'b0}}, r_o_rd, r_o_ld};
    assign m_axis_tuser  = {r_o_ev, r_o_dv};

endmodule

/* src/lfpd_regs.sv */
// APB configuration register file of the line follower PD drive block.
module lfpd_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lfpd_pkg::APB_AW-1:0]  paddr,
    input  logic [lfpd_pkg::APB_DW-1:0]  pwdata,
    output logic [lfpd_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    output lfpd_pkg::t_cfg               o_cfg
);
    import lfpd_pkg::*;

    t_cfg       r_cfg;
    logic       w_wr;
    logic [2:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[4:2];
    assign o_cfg  = r_cfg;

    // register writes in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp_gain         <= KP_RST;
            r_cfg.kd_gain         <= KD_RST;
            r_cfg.sense_level     <= THRESH_RST;
            r_cfg.center_position <= CENTER_RST;
            r_cfg.speed_limit     <= LIMIT_RST;
            r_cfg.error_deadband  <= DEADB_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_KP:     r_cfg.kp_gain         <= pwdata[GAIN_W-1:0];
                REG_KD:     r_cfg.kd_gain         <= pwdata[GAIN_W-1:0];
                REG_THRESH: r_cfg.sense_level     <= pwdata[SENSE_W-1:0];
                REG_CENTER: r_cfg.center_position <= pwdata[POS_W-1:0];
                REG_LIMIT:  r_cfg.speed_limit     <= pwdata[LIMIT_W-1:0];
                REG_DEADB:  r_cfg.error_deadband  <= pwdata[SENSE_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        prdata = '0;
        case (w_idx)
            REG_KP:     prdata = {{(APB_DW-GAIN_W){1'b0}}, r_cfg.kp_gain};
            REG_KD:     prdata = {{(APB_DW-GAIN_W){1'b0}}, r_cfg.kd_gain};
            REG_THRESH: prdata = {{(APB_DW-SENSE_W){1'b0}}, r_cfg.sense_level};
            REG_CENTER: prdata = {{(APB_DW-POS_W){1'b0}}, r_cfg.center_position};
            REG_LIMIT:  prdata = {{(APB_DW-LIMIT_W){1'b0}}, r_cfg.speed_limit};
            REG_DEADB:  prdata = {{(APB_DW-SENSE_W){1'b0}}, r_cfg.error_deadband};
            default:    prdata = '0;
        endcase
    end

endmodule

/* src/lfpd_checker.sv */
// Port-level checker of the line follower PD drive block, with its bind.
module lfpd_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [lfpd_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input logic [lfpd_pkg::M_TUSER_W-1:0]  m_axis_tuser,
    input logic                            pready
);
    import lfpd_pkg::*;

    // a crossing event always carries a drive command
    a_event_drives: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> m_axis_tuser[0])
        else $error("crossing event without drive_valid");

    // no drive command means both drives read zero
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("nonzero drive without drive_valid");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("result changed under stall");

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result offered right after reset");

    // configuration port never waits
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind line_follow_pd_drive_top lfpd_checker u_lfpd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .pready        (pready)
);

/* tb/line_follow_pd_drive_top_tb.sv */
// Self-checking stream testbench for the line follower PD drive block.
`timescale 1ns / 1ps

module line_follow_pd_drive_top_tb;
    import lfpd_pkg::*;

    // One input item and one drive result, field by field
    typedef struct packed {
        t_cmd                                  cmd;
        logic [POS_W-1:0]                      line_pos;
        logic [SENSOR_FIELDS-1:0][SENSE_W-1:0] sensor;
        logic [SPEED_W-1:0]                    left_speed;
        logic [SPEED_W-1:0]                    right_speed;
    } t_sample;

    typedef struct packed {
        logic [SPEED_W-1:0] left_drive;
        logic [SPEED_W-1:0] right_drive;
        logic               drive_valid;
        logic               crossing_event;
    } t_drive_res;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [S_TUSER_W-1:0] s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [M_TUSER_W-1:0] m_axis_tuser;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [APB_AW-1:0]    paddr = '0;
    logic [APB_DW-1:0]    pwdata = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    line_follow_pd_drive_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #1 i_clk = ~i_clk;

    // Register copy (gains, threshold, center, limit, deadband), tracked at each register write
    logic [GAIN_W-1:0]  cfg_kp     = KP_RST;
    logic [GAIN_W-1:0]  cfg_kd     = KD_RST;
    logic [SENSE_W-1:0] cfg_thresh = THRESH_RST;
    logic [POS_W-1:0]   cfg_center = CENTER_RST;
    logic [LIMIT_W-1:0] cfg_limit  = LIMIT_RST;
    logic [SENSE_W-1:0] cfg_deadb  = DEADB_RST;

    // Drive state of the predictor
    int last_err = 0;
    bit crossing_seen = 1'b0;
    int left_base = 0, right_base = 0;
    int saved_left = 0, saved_right = 0;

    t_sample    sample_q[$];
    t_drive_res drive_expect_q[$];
    t_sample    cur_item;

    int items_queued = 0, items_accepted = 0, phase_items = 0;
    int mismatch_count = 0, results_seen = 0, crossing_stops = 0, silent_samples = 0;
    int gain_settings = 1, long_holds = 0;
    int burst_left = 0, gap_left = 0;
    int rx_cycle = 0, hold_left = 0, rx_mode = 0, rx_mode_left = 0;

    function automatic int clip(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // PD update for one item; advances the predictor state
    function automatic t_drive_res pd_drive_predict(input t_sample it);
        t_drive_res r;
        int err, sum, corr, lim, ld, rd, pos_i, center_i;
        bit all_line;
        r = '0;
        case (it.cmd)
            CMD_SAMPLE: begin
                all_line = 1'b1;
                for (int k = 0; k < SENSOR_FIELDS; k++)
                    if (it.sensor[k] <= cfg_thresh) all_line = 1'b0;
                // first sample on a crossing stops the robot
                if (all_line && !crossing_seen) begin
                    saved_left  = left_base;
                    saved_right = right_base;
                    left_base   = 0;
                    right_base  = 0;
                    r.crossing_event = 1'b1;
                    r.drive_valid    = 1'b1;
                end
                crossing_seen = all_line;
                pos_i    = int'(it.line_pos);
                center_i = int'(cfg_center);
                err  = clip(pos_i - center_i, -4096, 4095);
                sum  = int'(cfg_kp) * err + int'(cfg_kd) * (err - last_err);
                corr = sum / 256;   // truncates toward zero
                last_err = err;
                lim = int'(cfg_limit);
                // stopped robot near the line center stays silent
                if (!(((err < 0) ? -err : err) < int'(cfg_deadb) &&
                      left_base == 0 && right_base == 0)) begin
                    ld = clip(left_base + corr, -lim, lim);
                    rd = clip(right_base - corr, -lim, lim);
                    r.left_drive  = ld[SPEED_W-1:0];
                    r.right_drive = rd[SPEED_W-1:0];
                    r.drive_valid = 1'b1;
                end
            end
            CMD_SET: begin
                saved_left  = left_base;
                saved_right = right_base;
                left_base   = int'($signed(it.left_speed));
                right_base  = int'($signed(it.right_speed));
                r.left_drive  = it.left_speed;
                r.right_drive = it.right_speed;
                r.drive_valid = 1'b1;
            end
            CMD_RESTORE: begin
                left_base   = saved_left;
                right_base  = saved_right;
                r.left_drive  = left_base[SPEED_W-1:0];
                r.right_drive = right_base[SPEED_W-1:0];
                r.drive_valid = 1'b1;
            end
            default: ;
        endcase
        return r;
    endfunction

    // Input driver: bursts with random gaps, predicts at each transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                drive_expect_q.push_back(pd_drive_predict(cur_item));
                items_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (sample_q.size() != 0) begin
                    cur_item = sample_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {3'b000, cur_item.right_speed, cur_item.left_speed,
                                      cur_item.sensor, cur_item.line_pos};
                    s_axis_tuser  <= cur_item.cmd;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result side ready: changing stall patterns plus periodic long hold-offs
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_cycle  <= 0;
            hold_left <= 0;
        end else begin
            rx_cycle <= rx_cycle + 1;
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end else if (rx_cycle % 1024 == 512) begin
                hold_left <= 64;
                long_holds <= long_holds + 1;
                m_axis_tready <= 1'b0;
            end else begin
                if (rx_mode_left == 0) begin
                    rx_mode      <= $urandom_range(0, 3);
                    rx_mode_left <= $urandom_range(8, 80);
                end else begin
                    rx_mode_left <= rx_mode_left - 1;
                end
                case (rx_mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= ~m_axis_tready;
                endcase
            end
        end
    end

    task automatic check_field(input string fname, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
            mismatch_count++;
        end
    endtask

    // Result monitor: compare each transfer with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_drive_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (drive_expect_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, got tdata %h tuser %h",
                         $time, m_axis_tdata, m_axis_tuser);
                mismatch_count++;
            end else begin
                want = drive_expect_q.pop_front();
                results_seen++;
                if (want.crossing_event) crossing_stops++;
                if (!want.drive_valid) silent_samples++;
                check_field("left_drive", int'($signed(want.left_drive)),
                            int'($signed(m_axis_tdata[SPEED_W-1:0])));
                check_field("right_drive", int'($signed(want.right_drive)),
                            int'($signed(m_axis_tdata[2*SPEED_W-1:SPEED_W])));
                check_field("drive_valid", int'(want.drive_valid), int'(m_axis_tuser[0]));
                check_field("crossing_event", int'(want.crossing_event),
                            int'(m_axis_tuser[1]));
            end
        end
    end

    // APB register write: setup cycle, then access cycle
    task automatic apb_write(input logic [2:0] idx, input int unsigned val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_KP:     cfg_kp     = val[GAIN_W-1:0];
            REG_KD:     cfg_kd     = val[GAIN_W-1:0];
            REG_THRESH: cfg_thresh = val[SENSE_W-1:0];
            REG_CENTER: cfg_center = val[POS_W-1:0];
            REG_LIMIT:  cfg_limit  = val[LIMIT_W-1:0];
            default:    cfg_deadb  = val[SENSE_W-1:0];
        endcase
    endtask

    task automatic program_gains(input int kp, kd, thr, ctr, lim, db);
        apb_write(REG_KP, kp);
        apb_write(REG_KD, kd);
        apb_write(REG_THRESH, thr);
        apb_write(REG_CENTER, ctr);
        apb_write(REG_LIMIT, lim);
        apb_write(REG_DEADB, db);
        gain_settings++;
    endtask

    // Wait until every queued item went through and every result came back
    task automatic wait_drained();
        while (items_accepted != items_queued || drive_expect_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic queue_item(input t_sample s);
        sample_q.push_back(s);
        items_queued++;
        if (s.cmd != CMD_NOP) phase_items++;
    endtask

    function automatic t_sample mk_item(input t_cmd c, input int pos, input int sens,
                                        input int ls, input int rs);
        t_sample s;
        s.cmd = c;
        s.line_pos = POS_W'(pos);
        for (int k = 0; k < SENSOR_FIELDS; k++) s.sensor[k] = SENSE_W'(sens);
        s.left_speed  = SPEED_W'(ls);
        s.right_speed = SPEED_W'(rs);
        return s;
    endfunction

    function automatic int rand_speed();
        if ($urandom_range(0, 3) == 0) return $signed(10'($urandom));
        return int'($urandom_range(0, 800)) - 400;
    endfunction

    // Random sample; on_line puts every sensor above the threshold
    function automatic t_sample make_sample(input bit on_line);
        t_sample s;
        int pick, span, pos;
        s = mk_item(CMD_SAMPLE, 0, 0, rand_speed(), rand_speed());
        pick = $urandom_range(0, 99);
        span = int'(cfg_deadb) * 2 + 50;
        if (pick < 50)
            pos = clip(int'(cfg_center) + int'($urandom_range(0, 2 * span)) - span, 0, 8191);
        else if (pick < 85)
            pos = $urandom_range(0, 5000);
        else
            pos = $urandom_range(0, 8191);
        s.line_pos = POS_W'(pos);
        for (int k = 0; k < SENSOR_FIELDS; k++)
            s.sensor[k] = on_line ? SENSE_W'($urandom_range(int'(cfg_thresh) + 1, 1023))
                                  : SENSE_W'($urandom_range(0, 1023));
        if (!on_line) s.sensor[$urandom_range(0, SENSOR_FIELDS - 1)] =
            SENSE_W'($urandom_range(0, cfg_thresh));
        return s;
    endfunction

    // One well-formed driving sequence, or a bit of noise
    task automatic add_segment();
        int pick;
        t_sample s;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            if ($urandom_range(0, 6) == 0) queue_item(mk_item(CMD_SET, $urandom, $urandom, 0, 0));
            else queue_item(mk_item(CMD_SET, $urandom, $urandom, rand_speed(), rand_speed()));
            repeat ($urandom_range(2, 10)) queue_item(make_sample(1'b0));
        end else if (pick < 60) begin
            // approach, cross the intersection, leave, maybe resume
            repeat ($urandom_range(1, 3)) queue_item(make_sample(1'b0));
            repeat ($urandom_range(1, 4)) queue_item(make_sample(1'b1));
            repeat ($urandom_range(1, 4)) queue_item(make_sample(1'b0));
            if ($urandom_range(0, 1)) queue_item(mk_item(CMD_RESTORE, $urandom, $urandom,
                                                         rand_speed(), rand_speed()));
        end else if (pick < 85) begin
            repeat ($urandom_range(3, 8)) queue_item(make_sample($urandom_range(0, 9) == 0));
        end else if (pick < 93) begin
            queue_item(mk_item(CMD_RESTORE, $urandom, $urandom, rand_speed(), rand_speed()));
            repeat ($urandom_range(1, 3)) queue_item(make_sample(1'b0));
        end else begin
            s = mk_item(t_cmd'($urandom_range(0, 3)), $urandom_range(0, 8191), 0,
                        $urandom, $urandom);
            for (int k = 0; k < SENSOR_FIELDS; k++)
                s.sensor[k] = SENSE_W'($urandom_range(0, 1023));
            queue_item(s);
        end
    endtask

    // Main sequence: directed items at reset gains, then random phases
    initial begin : stimulus
        t_sample s;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_item(mk_item(CMD_SAMPLE, 2500, 0, 0, 0));        // stopped and centered
        queue_item(mk_item(CMD_NOP, 8191, 1023, -1, -1));      // unknown command
        queue_item(mk_item(CMD_SET, 0, 0, 100, 100));
        queue_item(mk_item(CMD_SAMPLE, 0, 0, 0, 0));           // far left, clamps
        queue_item(mk_item(CMD_SAMPLE, 5000, 0, 0, 0));
        queue_item(mk_item(CMD_SAMPLE, 8191, 500, 0, 0));      // error saturates high
        queue_item(mk_item(CMD_SAMPLE, 2500, 1000, 0, 0));     // crossing stop, PD silent
        queue_item(mk_item(CMD_SAMPLE, 2500, 1000, 0, 0));     // still on the crossing
        queue_item(mk_item(CMD_SAMPLE, 2500, 0, 0, 0));
        queue_item(mk_item(CMD_RESTORE, 0, 0, 0, 0));
        queue_item(mk_item(CMD_SET, 0, 0, -512, 511));         // set speeds unclamped
        queue_item(mk_item(CMD_SET, 0, 0, 400, -400));
        queue_item(mk_item(CMD_RESTORE, 0, 0, 0, 0));
        queue_item(mk_item(CMD_SAMPLE, 2600, 800, 0, 0));      // sensors at threshold
        queue_item(mk_item(CMD_SAMPLE, 0, 801, 0, 0));         // crossing with PD drive
        s = mk_item(CMD_SAMPLE, 8191, 1023, 0, 0);
        s.sensor[3] = 0;                                       // one sensor off the line
        queue_item(s);
        queue_item(mk_item(CMD_SET, 0, 0, 0, 0));
        queue_item(mk_item(CMD_SAMPLE, 2699, 0, 0, 0));        // just inside deadband
        queue_item(mk_item(CMD_SAMPLE, 2700, 0, 0, 0));        // on deadband edge
        queue_item(mk_item(CMD_SAMPLE, 2300, 0, 0, 0));
        queue_item(mk_item(CMD_SAMPLE, 2301, 0, 0, 0));
        queue_item(mk_item(CMD_RESTORE, 0, 0, 0, 0));
        queue_item(mk_item(CMD_SET, 8191, 1023, -1, -1));
        wait_drained();

        for (int ph = 1; ph <= 7; ph++) begin
            case (ph)
                2: program_gains(4095, 4095, 1000, 5000, 400, 1000);
                3: program_gains(0, 0, 0, 0, 0, 0);
                6: program_gains(KP_RST, KD_RST, THRESH_RST, CENTER_RST, LIMIT_RST, DEADB_RST);
                default: program_gains($urandom_range(0, 4095), $urandom_range(0, 1023),
                                       $urandom_range(0, 1000), $urandom_range(0, 5000),
                                       $urandom_range(0, 400), $urandom_range(0, 1000));
            endcase
            phase_items = 0;
            while (phase_items < 245) add_segment();
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        if (drive_expect_q.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, drive_expect_q.size());
            mismatch_count++;
        end
        $display("Checked %0d results over %0d gain settings with %0d long output stalls",
                 results_seen, gain_settings, long_holds);
        $display("Crossing stops: %0d, silent samples: %0d, mismatches: %0d",
                 crossing_stops, silent_samples, mismatch_count);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("Timeout with %0d of %0d items accepted", items_accepted, items_queued);
        $display("FAIL");
        $finish;
    end

endmodule

/* filelist.f */
src/lfpd_pkg.sv
src/lfpd_regs.sv
src/line_follow_pd_drive_top.sv
src/lfpd_checker.sv
tb/line_follow_pd_drive_top_tb.sv
